@@ sv/bcd_timestamp_difference_assert.svh @@
// Assertion macros for the BCD timestamp difference block.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef BCD_TIMESTAMP_DIFFERENCE_ASSERT_SVH
`define BCD_TIMESTAMP_DIFFERENCE_ASSERT_SVH

// Same-cycle implication.
`define BTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/btd_pkg.sv @@
// Shared types, constants and BCD/calendar helpers for the timestamp difference block.
// No dependencies.
package btd_pkg;

  localparam int unsigned StampW = 48;
  localparam int unsigned DiffW  = 32;

  localparam logic [DiffW-1:0] SecsPerDay  = 32'd86400;
  localparam logic [16:0]      DaysPerYear = 17'd365;
  localparam logic [19:0]      SecsPerHour = 20'd3600;
  localparam logic [19:0]      SecsPerMin  = 20'd60;
  localparam logic [7:0]       SkipYear    = 8'd100;

  localparam logic [8:0] DaysBefore [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  typedef struct packed {
    logic              eq;
    logic              unit_days;
    logic [StampW-1:0] late;
    logic [StampW-1:0] early;
  } order_t;

  typedef struct packed {
    logic       eq;
    logic       unit_days;
    logic [7:0] yr_late;
    logic [7:0] yr_early;
    logic [6:0] leaps_late;
    logic [6:0] leaps_early;
    logic [9:0] doy_late;
    logic [9:0] doy_early;
    logic [19:0] sod_late;
    logic [19:0] sod_early;
  } decode_t;

  typedef struct packed {
    logic             eq;
    logic             unit_days;
    logic [DiffW-1:0] day_cnt;
    logic [DiffW-1:0] sod_diff;
  } days_t;

  function automatic logic [7:0] bcd_val(logic [7:0] b);
    return 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
  endfunction

  function automatic logic is_leap(logic [7:0] y);
    return (y[1:0] == 2'b00) && (y != SkipYear);
  endfunction

  // leap years in [0, n)
  function automatic logic [6:0] leap_count(logic [7:0] n);
    logic [8:0] t;
    t = {1'b0, n} + 9'd3;
    return t[8:2] - 7'(n > SkipYear);
  endfunction

  function automatic logic [9:0] day_of_year(logic [7:0] yr, logic [7:0] mo, logic [7:0] dy);
    logic [3:0] idx;
    logic [9:0] d;
    if (mo == 8'd0) begin
      idx = 4'd0;
    end else if (mo > 8'd13) begin
      idx = 4'd12;
    end else begin
      idx = 4'(mo - 8'd1);
    end
    d = 10'(DaysBefore[idx]) + 10'(dy);
    if (mo >= 8'd3) begin
      d = d + 10'(is_leap(yr));
    end
    return d;
  endfunction

  function automatic logic [19:0] sec_of_day(logic [7:0] h, logic [7:0] m, logic [7:0] s);
    return 20'(h) * SecsPerHour + 20'(m) * SecsPerMin + 20'(s);
  endfunction

endpackage

@@ sv/bcd_timestamp_difference.sv @@
// Absolute difference between two packed-BCD calendar timestamps, in seconds or
// in whole days. A four-stage pipeline (order, BCD decode, day sum, scale) takes a
// new transaction every cycle while out_stall_i stays low; results pass through the
// order, decode, day-sum and scale registers. out_stall_i propagates back through
// the stage registers, so in_stall_o rises only when all four stages hold data.
// Depends on btd_pkg and the stage modules btd_order, btd_decode, btd_days, btd_scale.
`include "bcd_timestamp_difference_assert.svh"

module bcd_timestamp_difference import btd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [StampW-1:0] stamp_a_i,
  input  logic [StampW-1:0] stamp_b_i,
  input  logic              unit_days_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DiffW-1:0]  difference_o
);

  logic    s1_valid, s2_valid, s3_valid;
  logic    s1_ready, s2_ready, s3_ready, s4_ready;
  order_t  s1_data;
  decode_t s2_data;
  days_t   s3_data;

  assign in_stall_o = !s1_ready;

  btd_order u_order (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .ready_o     (s1_ready),
    .stamp_a_i   (stamp_a_i),
    .stamp_b_i   (stamp_b_i),
    .unit_days_i (unit_days_i),
    .valid_o     (s1_valid),
    .ready_i     (s2_ready),
    .data_o      (s1_data)
  );

  btd_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s2_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s3_ready),
    .data_o  (s2_data)
  );

  btd_days u_days (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s3_ready),
    .data_i  (s2_data),
    .valid_o (s3_valid),
    .ready_i (s4_ready),
    .data_o  (s3_data)
  );

  btd_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_valid),
    .ready_o (s4_ready),
    .data_i  (s3_data),
    .valid_o (out_valid_o),
    .ready_i (!out_stall_i),
    .diff_o  (difference_o)
  );

  `BTD_ASSERT_NOW(a_stall_full, in_stall_o, s1_valid && s2_valid && s3_valid && out_valid_o && out_stall_i, "input stalled while the pipeline has room")
  `BTD_ASSERT_NEXT(a_accept_lands, in_valid_i && !in_stall_o, s1_valid, "accepted transaction missing from first stage")
  `BTD_ASSERT_NEXT(a_equal_zero, s3_valid && s4_ready && s3_data.eq, out_valid_o && (difference_o == '0), "equal stamps did not give zero")

endmodule

@@ sv/btd_order.sv @@
// Stage 1: compare the two stamps, flag equality and order them late/early.
// Depends on btd_pkg.
module btd_order import btd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [StampW-1:0] stamp_a_i,
  input  logic [StampW-1:0] stamp_b_i,
  input  logic              unit_days_i,
  output logic              valid_o,
  input  logic              ready_i,
  output order_t            data_o
);

  logic   valid_q;
  order_t data_q, data_d;
  logic   a_gt, keys_eq;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    if (unit_days_i) begin
      keys_eq = stamp_a_i[47:24] == stamp_b_i[47:24];
      a_gt    = stamp_a_i[47:24] >  stamp_b_i[47:24];
    end else begin
      keys_eq = stamp_a_i == stamp_b_i;
      a_gt    = stamp_a_i >  stamp_b_i;
    end
    data_d.eq        = keys_eq;
    data_d.unit_days = unit_days_i;
    data_d.late      = a_gt ? stamp_a_i : stamp_b_i;
    data_d.early     = a_gt ? stamp_b_i : stamp_a_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ sv/btd_decode.sv @@
// Stage 2: convert BCD fields, compute day of year, leap counts and second of day.
// Depends on btd_pkg.
module btd_decode import btd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  order_t  data_i,
  output logic    valid_o,
  input  logic    ready_i,
  output decode_t data_o
);

  logic    valid_q;
  decode_t data_q, data_d;
  logic [7:0] yl, ye;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    yl = bcd_val(data_i.late[47:40]);
    ye = bcd_val(data_i.early[47:40]);
    data_d.eq          = data_i.eq;
    data_d.unit_days   = data_i.unit_days;
    data_d.yr_late     = yl;
    data_d.yr_early    = ye;
    data_d.leaps_late  = leap_count(yl);
    data_d.leaps_early = leap_count(ye);
    data_d.doy_late    = day_of_year(yl, bcd_val(data_i.late[39:32]),
                                     bcd_val(data_i.late[31:24]));
    data_d.doy_early   = day_of_year(ye, bcd_val(data_i.early[39:32]),
                                     bcd_val(data_i.early[31:24]));
    data_d.sod_late    = sec_of_day(bcd_val(data_i.late[23:16]),
                                    bcd_val(data_i.late[15:8]),
                                    bcd_val(data_i.late[7:0]));
    data_d.sod_early   = sec_of_day(bcd_val(data_i.early[23:16]),
                                    bcd_val(data_i.early[15:8]),
                                    bcd_val(data_i.early[7:0]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ sv/btd_days.sv @@
// Stage 3: sum whole years, leap days and day-of-year offsets; subtract seconds of day.
// Depends on btd_pkg.
module btd_days import btd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  decode_t data_i,
  output logic    valid_o,
  input  logic    ready_i,
  output days_t   data_o
);

  logic        valid_q;
  days_t       data_q, data_d;
  logic [7:0]  ydiff;
  logic [16:0] yr_days;
  logic [DiffW-1:0] yr_part;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    ydiff   = data_i.yr_late - data_i.yr_early;
    yr_days = 17'(ydiff) * DaysPerYear;
    if (data_i.yr_late > data_i.yr_early) begin
      yr_part = DiffW'(yr_days) + DiffW'(data_i.leaps_late) - DiffW'(data_i.leaps_early);
    end else begin
      yr_part = '0;
    end
    data_d.eq        = data_i.eq;
    data_d.unit_days = data_i.unit_days;
    data_d.day_cnt   = yr_part + DiffW'(data_i.doy_late) - DiffW'(data_i.doy_early);
    data_d.sod_diff  = DiffW'(data_i.sod_late) - DiffW'(data_i.sod_early);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ sv/btd_scale.sv @@
// Stage 4: scale days to seconds, select the unit and hold the result register.
// Depends on btd_pkg.
module btd_scale import btd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  days_t            data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [DiffW-1:0] diff_o
);

  logic             valid_q;
  logic [DiffW-1:0] diff_q, diff_d, secs;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    secs = data_i.day_cnt * SecsPerDay + data_i.sod_diff;
    if (data_i.eq) begin
      diff_d = '0;
    end else if (data_i.unit_days) begin
      diff_d = data_i.day_cnt;
    end else begin
      diff_d = secs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      diff_q <= diff_d;
    end
  end

  assign valid_o = valid_q;
  assign diff_o  = diff_q;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for bcd_timestamp_difference: directed corner stamps, then random
// stamp pairs under four sender/receiver idling phases, checked by an in-order scoreboard.
// Depends on btd_pkg and the bcd_timestamp_difference RTL.
`timescale 1ns / 100ps

module testbench;
  import btd_pkg::*;

  localparam int unsigned MonthStart [13] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365
  };
  localparam int RandomPerPhase = 150;

  class diff_scoreboard;
    logic [DiffW-1:0] pending_diffs [$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int unsigned bcd_value(logic [7:0] b);
      return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function int unsigned leap_flag(int unsigned y);
      return (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 1 : 0;
    endfunction

    function logic [63:0] day_number(logic [StampW-1:0] s);
      int unsigned mo;
      int unsigned idx;
      logic [63:0] d;
      mo = bcd_value(s[39:32]);
      idx = (mo == 0) ? 0 : mo - 1;
      if (idx > 12) begin
        idx = 12;
      end
      d = 64'(MonthStart[idx]) + 64'(bcd_value(s[31:24]));
      if (mo >= 3) begin
        d = d + 64'(leap_flag(bcd_value(s[47:40])));
      end
      return d;
    endfunction

    function logic [63:0] second_number(logic [StampW-1:0] s);
      return 64'(bcd_value(s[23:16])) * 64'd3600 + 64'(bcd_value(s[15:8])) * 64'd60
           + 64'(bcd_value(s[7:0]));
    endfunction

    function logic [DiffW-1:0] elapsed_time(logic [StampW-1:0] a, logic [StampW-1:0] b,
                                            logic unit_days);
      logic [StampW-1:0] key_a;
      logic [StampW-1:0] key_b;
      logic [StampW-1:0] late;
      logic [StampW-1:0] early;
      logic [63:0] days;
      logic [63:0] total;
      int unsigned yr;
      key_a = unit_days ? {24'd0, a[47:24]} : a;
      key_b = unit_days ? {24'd0, b[47:24]} : b;
      if (key_a == key_b) begin
        return '0;
      end
      late = (key_a > key_b) ? a : b;
      early = (key_a > key_b) ? b : a;
      days = '0;
      for (yr = bcd_value(early[47:40]); yr < bcd_value(late[47:40]); yr++) begin
        days = days + 64'd365 + 64'(leap_flag(yr));
      end
      days = days + day_number(late) - day_number(early);
      if (unit_days) begin
        total = days;
      end else begin
        total = days * 64'd86400 + second_number(late) - second_number(early);
      end
      return total[DiffW-1:0];
    endfunction

    function void note_input(logic [StampW-1:0] a, logic [StampW-1:0] b, logic unit_days);
      pending_diffs.push_back(elapsed_time(a, b, unit_days));
    endfunction

    function void check_result(logic [DiffW-1:0] actual);
      logic [DiffW-1:0] expected;
      if (pending_diffs.size() == 0) begin
        $error("difference: expected none, actual %0d", actual);
        mismatches++;
        return;
      end
      expected = pending_diffs.pop_front();
      if (actual !== expected) begin
        $error("difference: expected %0d, actual %0d", expected, actual);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_diffs.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [StampW-1:0] stamp_a_i = '0;
  logic [StampW-1:0] stamp_b_i = '0;
  logic              unit_days_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [DiffW-1:0]  difference_o;

  diff_scoreboard sb;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  bcd_timestamp_difference DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .stamp_a_i   (stamp_a_i),
    .stamp_b_i   (stamp_b_i),
    .unit_days_i (unit_days_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .difference_o(difference_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && sb != null) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_input(stamp_a_i, stamp_b_i, unit_days_i);
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(difference_o);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("bcd_timestamp_difference regression: fail");
    $finish;
  end

  function automatic logic [7:0] to_bcd(int unsigned v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic logic [StampW-1:0] random_calendar_stamp();
    return {to_bcd($urandom_range(0, 99)), to_bcd($urandom_range(1, 12)),
            to_bcd($urandom_range(1, 31)), to_bcd($urandom_range(0, 23)),
            to_bcd($urandom_range(0, 59)), to_bcd($urandom_range(0, 59))};
  endfunction

  function automatic logic [StampW-1:0] random_raw_stamp();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic send_stamps(input logic [StampW-1:0] a, input logic [StampW-1:0] b,
                             input logic unit_days);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    stamp_a_i   <= a;
    stamp_b_i   <= b;
    unit_days_i <= unit_days;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_random_pair();
    logic [StampW-1:0] a;
    logic [StampW-1:0] b;
    int unsigned pick;
    int unsigned field;
    pick = $urandom_range(99);
    a = random_calendar_stamp();
    b = random_calendar_stamp();
    if (pick >= 70 && pick < 85) begin
      b = a;
      field = $urandom_range(0, 6);
      if (field < 6) begin
        b[8*field +: 8] = to_bcd($urandom_range(0, 59));
      end
    end else if (pick >= 85) begin
      a = random_raw_stamp();
      b = ($urandom_range(1) == 1) ? random_raw_stamp() : b;
    end
    if ($urandom_range(1) == 1) begin
      send_stamps(b, a, 1'($urandom_range(1)));
    end else begin
      send_stamps(a, b, 1'($urandom_range(1)));
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_corner_stamps();
    send_stamps(48'h000000_000000, 48'h000000_000000, 1'b0);
    send_stamps(48'hFFFFFF_FFFFFF, 48'hFFFFFF_FFFFFF, 1'b1);
    send_stamps(48'h000000_000000, 48'hFFFFFF_FFFFFF, 1'b0);
    send_stamps(48'hFFFFFF_FFFFFF, 48'h000000_000000, 1'b1);
    send_stamps(48'h240315_101010, 48'h240315_235959, 1'b1);
    send_stamps(48'h240315_101010, 48'h240315_235959, 1'b0);
    send_stamps(48'h991231_235959, 48'h000101_000000, 1'b0);
    send_stamps(48'h000101_000000, 48'h991231_235959, 1'b1);
    send_stamps(48'h240228_120000, 48'h240301_120000, 1'b1);
    send_stamps(48'h230228_120000, 48'h230301_120000, 1'b0);
    send_stamps(48'h000228_000000, 48'h000301_000000, 1'b1);
    send_stamps(48'h100005_000000, 48'h100101_000000, 1'b1);
    send_stamps(48'h101301_000000, 48'h101231_000000, 1'b1);
    send_stamps(48'h109901_000000, 48'h101501_000000, 1'b0);
    send_stamps(48'hA00101_000000, 48'h9F0101_000000, 1'b1);
    send_stamps(48'hA00101_000000, 48'h9F0101_000000, 1'b0);
    send_stamps(48'h501001_000000, 48'h500F01_000000, 1'b1);
    send_stamps(48'h501001_000000, 48'h500F01_000000, 1'b0);
    send_stamps(48'h200102_000000, 48'h200101_235959, 1'b0);
    send_stamps(48'h200101_FF0000, 48'h200101_00FFFF, 1'b0);
    send_stamps(48'h960229_000000, 48'h040301_000000, 1'b1);
    send_stamps(48'h550A0A_AAAAAA, 48'hAA5555_555555, 1'b0);
  endtask

  initial begin
    int src_pcts [4];
    int sink_pcts [4];
    src_pcts = '{0, 50, 0, 31};
    sink_pcts = '{0, 0, 50, 31};
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_corner_stamps();
    for (int phase = 0; phase < 4; phase++) begin
      src_idle_pct = src_pcts[phase];
      sink_stall_pct = sink_pcts[phase];
      for (int n = 0; n < RandomPerPhase; n++) begin
        send_random_pair();
      end
      drain_results();
    end
    sink_stall_pct = 0;
    repeat (16) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("bcd_timestamp_difference regression: pass");
    end else begin
      $display("bcd_timestamp_difference regression: fail");
    end
    $finish;
  end

endmodule
